// File: design/sai_pkg.sv
`default_nettype none
package sai_pkg;

    // Default number of stored entries
    localparam int DEPTH_DEF = 256;

    // Field widths
    localparam int TYPE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;
    localparam int CAP_W   = 9;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = PADDR_W - 2;
    localparam logic [REG_W-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Request kinds
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
    } t_res;

endpackage
`default_nettype wire

// File: design/sai_ram.sv
`default_nettype none
module sai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/sorted_array_insert_remove_unit.sv
// Sorted list of up to DEPTH unsigned 32-bit values held in one single-port-write,
// registered-read RAM. An insert walks down from the top entry, moving each entry
// that is not smaller than the new value up one place, then drops the value in.
// A remove walks up from the index, moving each later entry down one place. Each
// request ends in a last step that loads the result beat and stretches while the
// output register still holds an unaccepted beat. The walks are paced by the one RAM
// read per cycle. The block works on one request at a time; a finished result may
// wait in the output register while the next request is taken. No clearing pass
// is needed after reset.
`default_nettype none
module sorted_array_insert_remove_unit #(
    parameter int DEPTH = sai_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Request channel
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire sai_pkg::t_req                i_req,
    // Result channel
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output sai_pkg::t_res                     o_res,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sai_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sai_pkg::PDATA_W-1:0]  pwdata,
    output logic      [sai_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    import sai_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_RD_WAIT,
        S_REM_MOV,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [VALUE_W-1:0] r_rdval, n_rdval;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;
    logic [CAP_W-1:0]   r_cap;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    logic               req_fire, full, pos_bad;
    logic [CW-1:0]      cnt_c, pos_c, pos_p1_c, ptr_p2_c;
    logic [CNT_W-1:0]   cnt_m1, ptr_m1, ptr_m2, ptr_p1, ptr_p2, pos_t, pos_p1;
    logic [REG_W-1:0]   reg_idx;

    // Entry store
    sai_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Index arithmetic
    assign req_fire = i_req_valid && o_req_ready;
    assign cnt_c    = CW'(r_cnt);
    assign pos_c    = CW'(i_req.position);
    assign pos_p1_c = pos_c + CW'(1);
    assign ptr_p2_c = CW'(r_ptr) + CW'(2);
    assign pos_t    = CNT_W'(pos_c);
    assign pos_p1   = CNT_W'(pos_p1_c);
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign ptr_m1   = r_ptr - CNT_W'(1);
    assign ptr_m2   = r_ptr - CNT_W'(2);
    assign ptr_p1   = r_ptr + CNT_W'(1);
    assign ptr_p2   = CNT_W'(ptr_p2_c);
    assign full     = (cnt_c >= CW'(r_cap)) || (r_cnt >= DEPTH_C);
    assign pos_bad  = pos_c >= cnt_c;

    // Request sequencer: one RAM read and one RAM write per cycle
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_value     = r_value;
        n_rdval     = r_rdval;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr[AW-1:0];
        ram_wdata   = r_value;
        ram_re      = 1'b0;
        ram_raddr   = ptr_m2[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_value  = i_req.item_value;
                    n_rdval  = '0;
                    n_status = ST_OK;
                    n_ptr    = r_cnt;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (r_cnt == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = cnt_m1[AW-1:0];
                                n_state   = S_INS_CMP;
                            end
                        end
                        REQ_READ: begin
                            if (pos_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_t[AW-1:0];
                                n_state   = S_RD_WAIT;
                            end
                        end
                        REQ_REMOVE: begin
                            n_ptr = pos_t;
                            if (pos_bad) begin
                                n_status = ST_RANGE;
                                n_ptr    = r_ptr;
                            end else if (pos_p1_c == cnt_c) begin
                                n_cnt = cnt_m1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_p1[AW-1:0];
                                n_state   = S_REM_MOV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Entry below r_ptr is in ram_rdata; move it up or place the value
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata >= r_value) begin
                    ram_wdata = ram_rdata;
                    n_ptr     = ptr_m1;
                    if (r_ptr == CNT_W'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_m2[AW-1:0];
                    end
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_INS_PUT: begin
                ram_we  = 1'b1;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_DONE;
            end

            S_RD_WAIT: begin
                n_rdval = ram_rdata;
                n_state = S_DONE;
            end

            // Entry above r_ptr is in ram_rdata; move it down
            S_REM_MOV: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_ptr     = ptr_p1;
                if (ptr_p2_c < cnt_c) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p2[AW-1:0];
                end else begin
                    n_cnt   = cnt_m1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out.status     = r_status;
                    n_out.read_value = r_rdval;
                    n_out.count      = cnt_c[COUNT_W-1:0];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && reg_idx == REG_CAPACITY) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_rdval  <= n_rdval;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Configuration read
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_CAPACITY) ? PDATA_W'(r_cap) : '0;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("entry count beyond depth");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("RAM read and write hit the same entry");

    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_CMP |-> r_ptr != '0)
        else $error("insert walk below entry zero");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_OK |-> o_res.read_value == '0)
        else $error("error result carries read data");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_status != ST_OK |-> $stable(r_cnt))
        else $error("failed request changed the count");

endmodule
`default_nettype wire

// File: tb/tb_sorted_array_insert_remove_unit.sv
`default_nettype none
module tb_sorted_array_insert_remove_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sai_pkg::*;

    // Request kind the block ignores
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = DEPTH_DEF + 40;
    localparam int DIR_N       = 23;
    localparam int PHASE_N     = 6;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // One directed beat; the result is typed in only where fixed is set
    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        logic               fixed;
        logic [STAT_W-1:0]  st;
        logic [VALUE_W-1:0] rd;
        logic [COUNT_W-1:0] cnt;
    } t_dir_row;

    typedef struct {
        int   cap;
        int   items;
        int   snd_pct;
        int   rcv_pct;
        t_mix mix;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_res_valid;
    logic i_res_ready = 1'b0;
    t_res o_res;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Typed-in expectation riding along with the request payload
    logic req_fixed = 1'b0;
    t_res req_fixed_res = '0;

    // Shadow of the sorted store and its capacity register
    logic [VALUE_W-1:0] held [DEPTH_DEF];
    int                 held_n = 0;
    logic [CAP_W-1:0]   cap_reg = CAP_RESET;

    t_res res_q [$];
    int   sent_n = 0;
    int   done_n = 0;
    int   err_n = 0;
    int   cycle_n = 0;
    int   snd_pct = 0;
    int   rcv_pct = 0;
    int   kind_n [4] = '{0, 0, 0, 0};
    int   full_n = 0;
    int   range_n = 0;
    int   peak_n = 0;

    t_dir_row dir_tab [DIR_N] = '{
        '{REQ_READ,   32'h0,          8'd0,   1'b1, ST_RANGE, 32'h0,          9'd0},
        '{REQ_REMOVE, 32'h0,          8'd0,   1'b1, ST_RANGE, 32'h0,          9'd0},
        '{REQ_UNUSED, 32'hFFFF_FFFF,  8'd255, 1'b1, ST_OK,    32'h0,          9'd0},
        '{REQ_INSERT, 32'hFFFF_FFFF,  8'd0,   1'b1, ST_OK,    32'h0,          9'd1},
        '{REQ_INSERT, 32'h0,          8'd255, 1'b1, ST_OK,    32'h0,          9'd2},
        '{REQ_READ,   32'hFFFF_FFFF,  8'd0,   1'b1, ST_OK,    32'h0,          9'd2},
        '{REQ_READ,   32'h0,          8'd1,   1'b1, ST_OK,    32'hFFFF_FFFF,  9'd2},
        '{REQ_READ,   32'h0,          8'd2,   1'b1, ST_RANGE, 32'h0,          9'd2},
        '{REQ_READ,   32'h0,          8'd255, 1'b1, ST_RANGE, 32'h0,          9'd2},
        '{REQ_INSERT, 32'h8000_0000,  8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_INSERT, 32'h7FFF_FFFF,  8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_INSERT, 32'h8000_0000,  8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_INSERT, 32'h0,          8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_READ,   32'h0,          8'd2,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_READ,   32'h0,          8'd3,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_REMOVE, 32'h0,          8'd5,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_REMOVE, 32'h0,          8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_REMOVE, 32'hFFFF_FFFF,  8'd255, 1'b1, ST_RANGE, 32'h0,          9'd4},
        '{REQ_READ,   32'h0,          8'd3,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_UNUSED, 32'h0,          8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_REMOVE, 32'h0,          8'd1,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_INSERT, 32'h0000_0001,  8'd0,   1'b0, ST_OK,    32'h0,          9'd0},
        '{REQ_READ,   32'h0,          8'd0,   1'b0, ST_OK,    32'h0,          9'd0}
    };

    // Fill to the top, then drain below a lowered capacity, then odd settings
    t_phase phases [PHASE_N] = '{
        '{256, 290, 0,  0,  MIX_FILL},
        '{40,  280, 66, 0,  MIX_DRAIN},
        '{0,   80,  0,  66, MIX_EVEN},
        '{1,   100, 33, 33, MIX_EVEN},
        '{511, 100, 33, 33, MIX_FILL},
        '{7,   80,  0,  0,  MIX_EVEN}
    };

    sorted_array_insert_remove_unit #(.DEPTH(DEPTH_DEF)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sorted-store predictor: applies one request to the shadow, returns its result
    function automatic t_res apply_request(input t_req r);
        t_res res;
        int   lim;
        int   slot;
        res = '0;
        res.status = ST_OK;
        lim = (int'(cap_reg) < DEPTH_DEF) ? int'(cap_reg) : DEPTH_DEF;
        case (r.req_type)
            REQ_INSERT: begin
                if (held_n >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    // a new value goes in before its equals: stop at first not-smaller
                    slot = 0;
                    while (slot < held_n && held[slot] < r.item_value) slot++;
                    for (int k = held_n; k > slot; k--) held[k] = held[k-1];
                    held[slot] = r.item_value;
                    held_n++;
                end
            end
            REQ_READ: begin
                if (int'(r.position) < held_n) res.read_value = held[r.position];
                else res.status = ST_RANGE;
            end
            REQ_REMOVE: begin
                if (int'(r.position) < held_n) begin
                    for (int k = r.position; k + 1 < held_n; k++) held[k] = held[k+1];
                    held_n--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(held_n);
        return res;
    endfunction

    // Random request shaped by the phase mix and the current fill level
    function automatic t_req pick_request(input t_mix mix);
        t_req r;
        int   roll;
        int   n_ins;
        int   n_rd;
        int   n_rm;
        n_ins = (mix == MIX_FILL) ? 92 : (mix == MIX_DRAIN) ? 20 : 40;
        n_rd  = (mix == MIX_FILL) ? 5  : (mix == MIX_DRAIN) ? 15 : 33;
        n_rm  = (mix == MIX_FILL) ? 2  : (mix == MIX_DRAIN) ? 63 : 24;
        roll = $urandom_range(99);
        if (roll < n_ins) r.req_type = REQ_INSERT;
        else if (roll < n_ins + n_rd) r.req_type = REQ_READ;
        else if (roll < n_ins + n_rd + n_rm) r.req_type = REQ_REMOVE;
        else r.req_type = REQ_UNUSED;

        // values: wide random, small for duplicates, extremes, copies of stored ones
        roll = $urandom_range(99);
        if (roll < 35) begin
            r.item_value = $urandom;
        end else if (roll < 60) begin
            r.item_value = $urandom_range(15);
        end else if (roll < 70) begin
            case ($urandom_range(3))
                0: r.item_value = 32'h0;
                1: r.item_value = 32'hFFFF_FFFF;
                2: r.item_value = 32'h8000_0000;
                default: r.item_value = 32'h7FFF_FFFF;
            endcase
        end else if (roll < 85 && held_n > 0) begin
            r.item_value = held[$urandom_range(held_n - 1)];
        end else begin
            r.item_value = $urandom;
        end

        // index: mostly in range, with the last entry and first past it favored
        roll = $urandom_range(99);
        if (held_n == 0 || roll < 10) r.position = $urandom_range(255);
        else if (roll < 20) r.position = POS_W'(held_n - 1);
        else if (roll < 25 && held_n < DEPTH_DEF) r.position = POS_W'(held_n);
        else r.position = $urandom_range(held_n - 1);
        return r;
    endfunction

    // Result check, request prediction and register shadowing, all at the edge
    always @(posedge i_clk) begin : track
        t_res want;
        t_res got;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                got = o_res;
                if (res_q.size() == 0) begin
                    $error("result beat with no request outstanding: %p", got);
                    err_n++;
                end else begin
                    want = res_q.pop_front();
                    done_n++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_n++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, got.read_value);
                        err_n++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        err_n++;
                    end
                    if (got.status == ST_FULL) full_n++;
                    if (got.status == ST_RANGE) range_n++;
                end
            end
            if (i_req_valid && o_req_ready) begin
                want = apply_request(i_req);
                if (req_fixed) want = req_fixed_res;
                res_q.push_back(want);
                kind_n[i_req.req_type]++;
                if (held_n > peak_n) peak_n = held_n;
            end
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
                cap_reg = pwdata[CAP_W-1:0];
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= rcv_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_n, sent_n - done_n);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One request beat: optional idle gap, then hold valid until accepted
    task automatic send_req(input t_req r, input logic fixed, input t_res fr);
        while ($urandom_range(99) < snd_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_req         <= r;
        req_fixed     <= fixed;
        req_fixed_res <= fr;
        do @(posedge i_clk); while (!o_req_ready);
        sent_n++;
    endtask

    // Wait until every request has its result back
    task automatic wait_idle();
        @(posedge i_clk);
        while (done_n != sent_n) @(posedge i_clk);
    endtask

    // APB access to the capacity register
    task automatic cfg_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_capacity(input int want);
        logic [PDATA_W-1:0] rd;
        cfg_access(1'b0, '0, rd);
        if (rd !== PDATA_W'(want)) begin
            $error("capacity readback: expected %0d, got %0d", want, rd);
            err_n++;
        end
    endtask

    initial begin : stim
        logic [PDATA_W-1:0] dummy;
        t_res fr;
        t_req r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_capacity(int'(CAP_RESET));

        // Directed beats at reset capacity, no idling
        for (int i = 0; i < DIR_N; i++) begin
            r.req_type      = dir_tab[i].kind;
            r.item_value    = dir_tab[i].val;
            r.position      = dir_tab[i].pos;
            fr.status       = dir_tab[i].st;
            fr.read_value   = dir_tab[i].rd;
            fr.count        = dir_tab[i].cnt;
            send_req(r, dir_tab[i].fixed, fr);
        end
        i_req_valid <= 1'b0;
        req_fixed   <= 1'b0;

        // Random phases; sender holds off until drained before each register write
        for (int p = 0; p < PHASE_N; p++) begin
            wait_idle();
            snd_pct = phases[p].snd_pct;
            rcv_pct = phases[p].rcv_pct;
            cfg_access(1'b1, PDATA_W'(phases[p].cap), dummy);
            check_capacity(phases[p].cap);
            for (int i = 0; i < phases[p].items; i++) begin
                send_req(pick_request(phases[p].mix), 1'b0, '0);
            end
            i_req_valid <= 1'b0;
        end

        wait_idle();
        rcv_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (res_q.size() != 0) begin
            $error("%0d expected results never arrived", res_q.size());
            err_n++;
        end

        $display("covered %0d requests under %0d capacity settings: %0d inserts, %0d reads,"
                 , sent_n, PHASE_N + 1, kind_n[REQ_INSERT], kind_n[REQ_READ]);
        $display("  %0d removes, %0d unused kinds; %0d full, %0d out of range, peak count %0d",
                 kind_n[REQ_REMOVE], kind_n[REQ_UNUSED], full_n, range_n, peak_n);
        if (err_n == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
design/sai_pkg.sv
design/sai_ram.sv
design/sorted_array_insert_remove_unit.sv
tb/tb_sorted_array_insert_remove_unit.sv
